>>> rtl/fac_pkg.sv
// ----------------------------------------------------------------------------
// fac_pkg
// Shared types and constants for the fully associative FIFO cache lookup.
// ----------------------------------------------------------------------------
package fac_pkg;

  localparam int unsigned ADDR_W  = 32;
  localparam int unsigned TAG_W   = 32;
  localparam int unsigned CNT_W   = 32;
  localparam int unsigned OFF_W   = 5;
  localparam int unsigned WAY_O_W = 3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMP,
    ST_UPD
  } state_t;

  typedef struct packed {
    logic capture;
    logic compare;
    logic commit;
  } ctrl_cmd_t;

endpackage

>>> rtl/fac_ctrl.sv
// ----------------------------------------------------------------------------
// fac_ctrl
// Sequencer: capture, tag compare, update/commit, output register valid.
// ----------------------------------------------------------------------------
module fac_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  output fac_pkg::ctrl_cmd_t cmd
);

  fac_pkg::state_t state_r, state_nxt;
  logic            out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= fac_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    cmd         = '0;
    in_ready    = 1'b0;
    case (state_r)
      fac_pkg::ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
        if (in_valid) begin
          state_nxt = fac_pkg::ST_CMP;
        end
      end
      fac_pkg::ST_CMP: begin
        cmd.compare = 1'b1;
        state_nxt   = fac_pkg::ST_UPD;
      end
      fac_pkg::ST_UPD: begin
        // hold until the output register is free or draining
        if (!out_valid_r || out_ready) begin
          cmd.commit = 1'b1;
          state_nxt  = fac_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = fac_pkg::ST_IDLE;
      end
    endcase

    if (cmd.commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign out_valid = out_valid_r;

endmodule

>>> rtl/fac_dpath.sv
// ----------------------------------------------------------------------------
// fac_dpath
// Tag store, valid bits, FIFO pointer, saturating counters, result register.
// ----------------------------------------------------------------------------
module fac_dpath #(
  parameter int unsigned WAYS  = 8,
  parameter int unsigned WAY_W = 3
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  fac_pkg::ctrl_cmd_t            cmd,
  input  logic                          cfg_we,
  input  logic [fac_pkg::OFF_W-1:0]     cfg_offset_bits,
  input  logic [fac_pkg::ADDR_W-1:0]    in_address,
  output logic                          out_hit,
  output logic [fac_pkg::WAY_O_W-1:0]   out_way,
  output logic                          out_evicted_valid,
  output logic [fac_pkg::TAG_W-1:0]     out_evicted_tag,
  output logic [fac_pkg::TAG_W-1:0]     out_tag_out,
  output logic [fac_pkg::CNT_W-1:0]     out_hit_count,
  output logic [fac_pkg::CNT_W-1:0]     out_miss_count
);

  logic [fac_pkg::OFF_W-1:0] offset_r;
  logic [fac_pkg::TAG_W-1:0] tag_r;
  logic [fac_pkg::TAG_W-1:0] store_r [WAYS];
  logic [WAYS-1:0]           valid_r;
  logic [WAYS-1:0]           match_r;
  logic [WAY_W-1:0]          ptr_r, ptr_nxt;
  logic [fac_pkg::CNT_W-1:0] hits_r, misses_r;

  logic                      hit_w;
  logic                      free_any_w;
  logic                      ev_valid_w;
  logic [WAY_W-1:0]          hit_way_w;
  logic [WAY_W-1:0]          free_way_w;
  logic [WAY_W-1:0]          way_w;
  logic [fac_pkg::TAG_W-1:0] ev_tag_w;
  logic [31:0]               way_ext_w;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_r <= '0;
    end else if (cfg_we) begin
      offset_r <= cfg_offset_bits;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      tag_r <= in_address >> offset_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.compare) begin
      for (int i = 0; i < WAYS; i++) begin
        match_r[i] <= valid_r[i] && (store_r[i] == tag_r);
      end
    end
  end

  // lowest matching way and lowest free way
  always_comb begin
    hit_way_w  = '0;
    free_way_w = '0;
    for (int i = WAYS - 1; i >= 0; i--) begin
      if (match_r[i]) begin
        hit_way_w = WAY_W'(i);
      end
      if (!valid_r[i]) begin
        free_way_w = WAY_W'(i);
      end
    end
  end

  assign hit_w      = |match_r;
  assign free_any_w = ~&valid_r;
  assign ev_valid_w = !hit_w && !free_any_w;
  assign way_w      = hit_w ? hit_way_w : (free_any_w ? free_way_w : ptr_r);
  assign ev_tag_w   = ev_valid_w ? store_r[ptr_r] : '0;
  assign way_ext_w  = 32'(way_w);
  assign ptr_nxt    = (ptr_r == WAY_W'(WAYS - 1)) ? '0 : ptr_r + WAY_W'(1);

  always_ff @(posedge clk) begin
    if (cmd.commit && !hit_w) begin
      store_r[way_w] <= tag_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      ptr_r    <= '0;
      hits_r   <= '0;
      misses_r <= '0;
    end else if (cmd.commit) begin
      if (hit_w) begin
        if (hits_r != '1) begin
          hits_r <= hits_r + 1'b1;
        end
      end else begin
        valid_r[way_w] <= 1'b1;
        if (misses_r != '1) begin
          misses_r <= misses_r + 1'b1;
        end
        if (ev_valid_w) begin
          ptr_r <= ptr_nxt;
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_hit           <= hit_w;
      out_way           <= way_ext_w[fac_pkg::WAY_O_W-1:0];
      out_evicted_valid <= ev_valid_w;
      out_evicted_tag   <= ev_tag_w;
      out_tag_out       <= tag_r;
      out_hit_count     <= (hit_w && hits_r != '1) ? hits_r + 1'b1 : hits_r;
      out_miss_count    <= (!hit_w && misses_r != '1) ? misses_r + 1'b1 : misses_r;
    end
  end

  a_evict_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit && ev_valid_w |-> &valid_r)
    else $error("eviction with a free way");

  a_ptr_moves_on_evict: assert property (@(posedge clk) disable iff (!rst_n)
    ptr_r != $past(ptr_r) |-> $past(cmd.commit && ev_valid_w))
    else $error("FIFO pointer moved without eviction");

  a_hits_only_on_commit: assert property (@(posedge clk) disable iff (!rst_n)
    hits_r != $past(hits_r) |-> $past(cmd.commit && hit_w))
    else $error("hit counter changed without a hit");

  a_valid_only_on_miss: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r != $past(valid_r) |-> $past(cmd.commit && !hit_w))
    else $error("valid bits changed without a fill");

endmodule

>>> rtl/fully_assoc_fifo_cache_lookup.sv
// Sequence: address capture, tag compare, then update into the result register;
//   the update waits while an undrained result holds the register and out_ready is low.
// Only one address is in flight: the next is taken once the previous one has updated.
// A new address is taken while the previous result still waits in its register.
// Reset (rst_n low, synchronous): all ways invalid, FIFO pointer, hit and miss
//   counts and offset_bits cleared; tag store contents are not cleared.
// ----------------------------------------------------------------------------
// fully_assoc_fifo_cache_lookup
// Fully associative tag lookup with FIFO replacement and saturating counts.
// ----------------------------------------------------------------------------
module fully_assoc_fifo_cache_lookup #(
  parameter int unsigned WAYS = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [fac_pkg::OFF_W-1:0]     cfg_offset_bits,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [fac_pkg::ADDR_W-1:0]    in_address,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_hit,
  output logic [fac_pkg::WAY_O_W-1:0]   out_way,
  output logic                          out_evicted_valid,
  output logic [fac_pkg::TAG_W-1:0]     out_evicted_tag,
  output logic [fac_pkg::TAG_W-1:0]     out_tag_out,
  output logic [fac_pkg::CNT_W-1:0]     out_hit_count,
  output logic [fac_pkg::CNT_W-1:0]     out_miss_count
);

  localparam int unsigned WAY_W = $clog2(WAYS);

  fac_pkg::ctrl_cmd_t cmd;

  assign cfg_ready = 1'b1;

  fac_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  fac_dpath #(
    .WAYS  (WAYS),
    .WAY_W (WAY_W)
  ) u_dpath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .cfg_we            (cfg_valid),
    .cfg_offset_bits   (cfg_offset_bits),
    .in_address        (in_address),
    .out_hit           (out_hit),
    .out_way           (out_way),
    .out_evicted_valid (out_evicted_valid),
    .out_evicted_tag   (out_evicted_tag),
    .out_tag_out       (out_tag_out),
    .out_hit_count     (out_hit_count),
    .out_miss_count    (out_miss_count)
  );

endmodule
